// ===== design/radix_number_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Radix number parser assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RADIX_NUMBER_PARSER_DEFINES_SVH
`define RADIX_NUMBER_PARSER_DEFINES_SVH

// same-cycle implication
`define RNP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rnp assertion failed");

// next-cycle implication
`define RNP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rnp assertion failed");

`endif

// ===== design/rnp_pkg.sv =====
// ---------------------------------------------------------------------------
// Radix number parser package
// Types, character constants and the character-to-digit decode.
// ---------------------------------------------------------------------------
`default_nettype none

package rnp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CH_W        = 8;
    localparam int RADIX_W     = 6;
    localparam int OUT_W       = 32;
    localparam int POS_W       = 2;

    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5a;

    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
    localparam logic [RADIX_W-1:0] LETTER_OFS = 6'd10;

    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0] POS_LATER  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic               is_end;
        logic [RADIX_W-1:0] radix;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             valid_res;
    } result_t;

    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] val;
    } digit_t;

    function automatic digit_t digit_of(input logic [CH_W-1:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c >= CH_0 && c <= CH_9)
        begin
            d.val = RADIX_W'(c - CH_0);
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            d.val = RADIX_W'(c - CH_LO_A) + LETTER_OFS;
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            d.val = RADIX_W'(c - CH_UP_A) + LETTER_OFS;
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/rnp_if.sv =====
// ---------------------------------------------------------------------------
// Radix number parser channels
// Valid/ready channels for characters in and parse results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface rnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;
    logic [5:0] radix;

    modport source (output valid, output ch, output is_end, output radix, input ready);
    modport sink   (input valid, input ch, input is_end, input radix, output ready);
endinterface

interface rnp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        valid_res;

    modport source (output valid, output value, output valid_res, input ready);
    modport sink   (input valid, input value, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== design/rnp_in_reg.sv =====
// ---------------------------------------------------------------------------
// Radix number parser input register
// One transaction per cycle unless stalled; held until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module rnp_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rnp_in_if.sink             din,
    output rnp_pkg::item_t     item,
    output logic               item_valid,
    input  wire logic          item_take
);
    import rnp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign din.ready  = !valid_reg || item_take;
    assign valid_next = din.valid ? 1'b1 : (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            item_reg.ch     <= din.ch;
            item_reg.is_end <= din.is_end;
            item_reg.radix  <= din.radix;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

// ===== design/rnp_parse_core.sv =====
// ---------------------------------------------------------------------------
// Radix number parser core
// Per-string state, digit check and multiply-add, result on end marker.
// ---------------------------------------------------------------------------
`default_nettype none
`include "radix_number_parser_defines.svh"

module rnp_parse_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rnp_pkg::item_t item,
    input  wire logic           item_valid,
    output logic                item_take,
    output rnp_pkg::result_t    res,
    output logic                res_load,
    input  wire logic           res_ready
);
    import rnp_pkg::*;

    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [RADIX_W-1:0]     base_reg, base_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   auto_reg, auto_next;
    logic                   fwz_reg, fwz_next;
    logic                   err_reg, err_next;

    logic [RADIX_W-1:0]     base_eff;
    logic                   auto_eff;
    digit_t                 dig;
    logic                   hex_prefix;

    assign item_take = item_valid && (!item.is_end || res_ready);
    assign res_load  = item_take && item.is_end;

    assign res.value     = err_reg ? '0 : OUT_W'(acc_reg);
    assign res.valid_res = !err_reg;

    always_comb
    begin
        if (pos_reg == POS_FIRST)
        begin
            auto_eff = (item.radix == RADIX_AUTO);
            base_eff = (item.radix == RADIX_AUTO) ? RADIX_DEC : item.radix;
        end
        else
        begin
            auto_eff = auto_reg;
            base_eff = base_reg;
        end

        dig        = digit_of(item.ch);
        hex_prefix = auto_eff && (pos_reg == POS_SECOND) && fwz_reg && (item.ch == CH_LO_X);

        acc_next  = acc_reg;
        base_next = base_reg;
        pos_next  = pos_reg;
        auto_next = auto_reg;
        fwz_next  = fwz_reg;
        err_next  = err_reg;

        if (item_take)
        begin
            if (item.is_end)
            begin
                acc_next  = '0;
                base_next = '0;
                pos_next  = POS_FIRST;
                auto_next = 1'b0;
                fwz_next  = 1'b0;
                err_next  = 1'b0;
            end
            else if (hex_prefix)
            begin
                auto_next = auto_eff;
                base_next = RADIX_HEX;
                fwz_next  = 1'b0;
                pos_next  = POS_LATER;
            end
            else
            begin
                auto_next = auto_eff;
                base_next = base_eff;
                if (auto_eff && pos_reg == POS_FIRST && item.ch == CH_0)
                begin
                    fwz_next = 1'b1;
                end
                else if (pos_reg != POS_FIRST)
                begin
                    fwz_next = 1'b0;
                end
                if (pos_reg != POS_LATER)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (!err_reg)
                begin
                    if (!dig.ok || dig.val >= base_eff)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = VALUE_WIDTH'(acc_reg * VALUE_WIDTH'(base_eff))
                                 + VALUE_WIDTH'(dig.val);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            base_reg <= '0;
            pos_reg  <= POS_FIRST;
            auto_reg <= 1'b0;
            fwz_reg  <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            base_reg <= base_next;
            pos_reg  <= pos_next;
            auto_reg <= auto_next;
            fwz_reg  <= fwz_next;
            err_reg  <= err_next;
        end
    end

    // string state clears after the end marker
    `RNP_ASSERT_NEXT(a_end_clears, res_load, pos_reg == POS_FIRST && !err_reg && acc_reg == '0)
    // a pending '0' prefix only exists in auto mode right after the first char
    `RNP_ASSERT_NOW(a_fwz_ctx, fwz_reg, auto_reg && pos_reg == POS_SECOND)
    // accumulator frozen once an error is seen
    `RNP_ASSERT_NEXT(a_err_hold, err_reg && !res_load, $stable(acc_reg))
    `RNP_ASSERT_NOW(a_fresh_clean, pos_reg == POS_FIRST, !err_reg && acc_reg == '0)

endmodule

`default_nettype wire

// ===== design/rnp_out_reg.sv =====
// ---------------------------------------------------------------------------
// Radix number parser output register
// Holds one result transaction until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module rnp_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rnp_pkg::result_t res,
    input  wire logic             res_load,
    output logic                  res_ready,
    rnp_out_if.source             dout
);
    import rnp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready  = !valid_reg || dout.ready;
    assign valid_next = res_load ? 1'b1 : (valid_reg && !dout.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign dout.valid     = valid_reg;
    assign dout.value     = res_reg.value;
    assign dout.valid_res = res_reg.valid_res;

endmodule

`default_nettype wire

// ===== design/radix_number_parser.sv =====
// ---------------------------------------------------------------------------
// Radix number parser
// Unsigned number parse from a character stream, base 2..36 or auto 10/16.
// ---------------------------------------------------------------------------
// Takes one transaction per cycle on din: a character, or an end marker that
// closes the string. The radix is sampled on the first transaction of each
// string; radix 0 picks base 10, or base 16 after a leading "0x". One result
// transaction (value modulo 2^32 and a valid flag, value 0 when invalid) leaves
// on dout for each end marker, after it passes the input and output registers.
// Throughput is one transaction per cycle, set by the combinational multiply-add
// of the core; the input register stalls only when an end marker meets a full
// output register that dout is not draining.
`default_nettype none

module radix_number_parser (
    input  wire logic clk,
    input  wire logic rst_n,
    rnp_in_if.sink    din,
    rnp_out_if.source dout
);
    import rnp_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t res;
    logic    res_load;
    logic    res_ready;

    rnp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    rnp_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res        (res),
        .res_load   (res_load),
        .res_ready  (res_ready)
    );

    rnp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_load  (res_load),
        .res_ready (res_ready),
        .dout      (dout)
    );

endmodule

`default_nettype wire
